/* rtl/ips_pkg.sv */
`default_nettype none

package ips_pkg;

	// Item opcodes
	typedef enum logic [1:0] {
		OP_TICK     = 2'd0,
		OP_PUMP_ON  = 2'd1,
		OP_PUMP_OFF = 2'd2,
		OP_TOGGLE   = 2'd3
	} op_t;

	// Register indexes
	localparam int unsigned CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_HOLDOFF  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WATER    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_HUM_LOW  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_HUM_HIGH = 2'd3;

	// Field widths
	localparam int unsigned CFG_W   = 12;
	localparam int unsigned HOLD_W  = 12;
	localparam int unsigned WATER_W = 6;
	localparam int unsigned HUM_W   = 10;
	localparam int unsigned CNT_W   = 16;

	// Register limits and reset values
	localparam logic [CFG_W-1:0]   HOLDOFF_MAX   = 12'd3600;
	localparam logic [CFG_W-1:0]   WATER_MAX     = 12'd59;
	localparam logic [CFG_W-1:0]   HUM_MAX       = 12'd1023;
	localparam logic [HOLD_W-1:0]  HOLDOFF_RST   = 12'd60;
	localparam logic [WATER_W-1:0] WATER_RST     = 6'd10;
	localparam logic [HUM_W-1:0]   HUM_LOW_RST   = 10'd307;
	localparam logic [HUM_W-1:0]   HUM_HIGH_RST  = 10'd716;

	// Settle time added to the hold-off before a cycle closes
	localparam logic [HOLD_W:0] SETTLE_SECONDS = 13'd5;

endpackage

`default_nettype wire

/* rtl/irrigation_pump_sequencer.sv */
// Irrigation pump sequencer. Each input transaction is either a tick (with a
// humidity sample and tank level) or a manual command (pump on, pump off,
// toggle); every transaction yields exactly one result transaction showing the
// pump, warning, latched tank level, latched humidity and cycle-active state
// after the update. All work is a few compares and one increment between the
// sequencer state and a single output register, so one transaction is taken
// every clock and its result appears in the cycle after acceptance; the only
// limit on throughput is the output register, which frees when the result is
// taken. Registers are written through cfg_we/cfg_index/cfg_wdata; values
// outside their legal range are dropped. Durations count ticks, with
// TICKS_PER_SECOND ticks to one second.
`default_nettype none

module irrigation_pump_sequencer import ips_pkg::*; #(
	parameter int unsigned TICKS_PER_SECOND = 10
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,

	// Configuration write port
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_wdata,

	// Input channel
	input  wire logic                 in_valid,
	output      logic                 in_ready,
	input  wire logic [1:0]           opcode,
	input  wire logic [HUM_W-1:0]     humidity_sample,
	input  wire logic                 tank_full,

	// Result channel
	output      logic                 out_valid,
	input  wire logic                 out_ready,
	output      logic                 pump_running,
	output      logic                 warning_signal,
	output      logic                 tank_ok,
	output      logic [HUM_W-1:0]     humidity_latched,
	output      logic                 cycle_active
);

	localparam int unsigned TPS_W  = $clog2(TICKS_PER_SECOND + 1);
	localparam int unsigned STOP_W = WATER_W + TPS_W;
	localparam int unsigned END_W  = HOLD_W + 1 + TPS_W;
	localparam int unsigned CMP_W  = (END_W > CNT_W) ? END_W : CNT_W;
	localparam logic [TPS_W-1:0] TPS_K = TPS_W'(TICKS_PER_SECOND);

	// Configuration registers
	logic [HOLD_W-1:0]  holdoff_q;
	logic [WATER_W-1:0] water_q;
	logic [HUM_W-1:0]   hum_low_q;
	logic [HUM_W-1:0]   hum_high_q;

	// Sequencer state
	logic              pump_q, sig_q, in_cycle_q, tank_q;
	logic [CNT_W-1:0]  ticks_q;
	logic [HUM_W-1:0]  hum_q;

	logic              pump_d, sig_d, in_cycle_d, tank_d;
	logic [CNT_W-1:0]  ticks_d;
	logic [HUM_W-1:0]  hum_d;

	logic              accept;
	op_t               op;
	logic [CNT_W-1:0]  ticks_inc;
	logic [STOP_W-1:0] stop_at;
	logic [HOLD_W:0]   settle_sum;
	logic [END_W-1:0]  end_at;

	// Output register frees when its result is taken
	assign in_ready = !out_valid || out_ready;
	assign accept   = in_valid && in_ready;
	assign op       = op_t'(opcode);

	// Register writes, out-of-range values dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			holdoff_q  <= HOLDOFF_RST;
			water_q    <= WATER_RST;
			hum_low_q  <= HUM_LOW_RST;
			hum_high_q <= HUM_HIGH_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_HOLDOFF: begin
					if (cfg_wdata <= HOLDOFF_MAX) holdoff_q <= cfg_wdata[HOLD_W-1:0];
				end
				REG_WATER: begin
					if (cfg_wdata != '0 && cfg_wdata <= WATER_MAX)
						water_q <= cfg_wdata[WATER_W-1:0];
				end
				REG_HUM_LOW: begin
					if (cfg_wdata != '0 && cfg_wdata <= HUM_MAX)
						hum_low_q <= cfg_wdata[HUM_W-1:0];
				end
				REG_HUM_HIGH: begin
					if (cfg_wdata != '0 && cfg_wdata <= HUM_MAX)
						hum_high_q <= cfg_wdata[HUM_W-1:0];
				end
				default: ;
			endcase
		end
	end

	// Timer limits in ticks
	assign stop_at    = STOP_W'(water_q) * STOP_W'(TPS_K);
	assign settle_sum = (HOLD_W+1)'(holdoff_q) + SETTLE_SECONDS;
	assign end_at     = END_W'(settle_sum) * END_W'(TPS_K);

	// Saturating cycle counter
	assign ticks_inc = (ticks_q != '1) ? ticks_q + CNT_W'(1) : ticks_q;

	// Next state for one item
	always_comb begin
		pump_d     = pump_q;
		sig_d      = sig_q;
		in_cycle_d = in_cycle_q;
		ticks_d    = ticks_q;
		hum_d      = hum_q;
		tank_d     = tank_q;
		unique case (op)
			OP_TICK: begin
				if (in_cycle_q) begin
					// both timer checks every tick
					ticks_d = ticks_inc;
					if (ticks_inc == CNT_W'(stop_at)) pump_d = 1'b0;
					if (CMP_W'(ticks_inc) >= CMP_W'(end_at)) begin
						in_cycle_d = 1'b0;
						ticks_d    = '0;
					end
				end else begin
					hum_d  = humidity_sample;
					tank_d = tank_full;
					if (!tank_full) begin
						sig_d  = !sig_q;
						pump_d = 1'b0;
					end else begin
						sig_d = 1'b0;
						// stop check wins when thresholds cross
						priority if (humidity_sample > hum_high_q) begin
							pump_d = 1'b0;
						end else if (humidity_sample < hum_low_q) begin
							pump_d     = 1'b1;
							in_cycle_d = 1'b1;
							ticks_d    = '0;
						end
					end
				end
			end
			OP_PUMP_ON: begin
				pump_d     = 1'b1;
				in_cycle_d = 1'b1;
				ticks_d    = '0;
			end
			OP_PUMP_OFF: begin
				pump_d     = 1'b0;
				in_cycle_d = 1'b0;
				ticks_d    = '0;
			end
			OP_TOGGLE: begin
				pump_d     = !pump_q;
				in_cycle_d = !pump_q;
				ticks_d    = '0;
			end
			default: ;
		endcase
	end

	// State update on accepted transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pump_q     <= 1'b0;
			sig_q      <= 1'b0;
			in_cycle_q <= 1'b0;
			ticks_q    <= '0;
			hum_q      <= '0;
			tank_q     <= 1'b0;
		end else if (accept) begin
			pump_q     <= pump_d;
			sig_q      <= sig_d;
			in_cycle_q <= in_cycle_d;
			ticks_q    <= ticks_d;
			hum_q      <= hum_d;
			tank_q     <= tank_d;
		end
	end

	// Result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (in_ready) begin
			out_valid <= in_valid;
		end
	end

	// Results are the state after the update
	assign pump_running     = pump_q;
	assign warning_signal   = sig_q;
	assign tank_ok          = tank_q;
	assign humidity_latched = hum_q;
	assign cycle_active     = in_cycle_q;

`ifndef ASSERT_OFF
	// Counter is cleared whenever no cycle is open
	a_idle_cnt_zero: assert property (@(posedge clk) disable iff (!arst_n)
		!in_cycle_q |-> ticks_q == '0)
		else $error("cycle counter nonzero outside a cycle");

	// Manual on opens a cycle with the pump running
	a_pump_on: assert property (@(posedge clk) disable iff (!arst_n)
		accept && op == OP_PUMP_ON |=> pump_q && in_cycle_q && ticks_q == '0)
		else $error("pump on did not open a cycle");

	// Manual off stops the pump and closes the cycle
	a_pump_off: assert property (@(posedge clk) disable iff (!arst_n)
		accept && op == OP_PUMP_OFF |=> !pump_q && !in_cycle_q)
		else $error("pump off left pump or cycle active");

	// Empty tank on an idle tick stops the pump and blinks the warning
	a_empty_tank: assert property (@(posedge clk) disable iff (!arst_n)
		accept && op == OP_TICK && !in_cycle_q && !tank_full
		|=> !pump_q && !tank_q && sig_q != $past(sig_q))
		else $error("empty tank not handled");
`endif

endmodule

`default_nettype wire
